// File: rtl/core/multi_wave_tone_generator_macros.svh
// assertion macros shared by the tone generator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef MULTI_WAVE_TONE_GENERATOR_MACROS_SVH
`define MULTI_WAVE_TONE_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define MWTG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mwtg same-cycle check failed");

// next-cycle implication, checked outside reset
`define MWTG_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mwtg next-cycle check failed");

`endif

// File: rtl/core/mwtg_pkg.sv
// shared types, constants and the triangle table of the tone generator
// no dependencies
package mwtg_pkg;

    localparam int OSC_W      = 32;
    localparam int PROD_W     = 2 * OSC_W;
    localparam int Q_FRAC     = 30;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 8;

    localparam int TRI_PERIOD  = 256;
    localparam int TRI_PHASE_W = $clog2(TRI_PERIOD);
    localparam int TRI_QUARTER = TRI_PERIOD / 4;
    localparam int TRI_HALF    = TRI_PERIOD / 2;
    localparam int TRI_THREEQ  = 3 * TRI_PERIOD / 4;
    localparam int LEVEL_INT   = 16000;

    localparam logic signed [SAMPLE_W-1:0] LEVEL      = 16'sd16000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [OSC_W-1:0]    OSC_MAX    = 32'sh7fffffff;
    localparam logic signed [OSC_W-1:0]    OSC_MIN    = 32'sh80000000;
    localparam logic signed [OSC_W-1:0]    SINE_SCALE = 32'sd32000;
    localparam logic signed [PROD_W-1:0]   TRUNC_BIAS = PROD_W'((64'd1 << Q_FRAC) - 64'd1);

    localparam logic signed [OSC_W-1:0] COEFF_A_RESET     = 32'sd2142885721;
    localparam logic signed [OSC_W-1:0] START_VALUE_RESET = 32'sd70226075;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SINE_DEF = 2'd3
    } wave_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE_TYPE   = 2'd0,
        REG_COEFF_A     = 2'd1,
        REG_START_VALUE = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_SCALE_MUL,
        ST_SCALE_OUT
    } state_t;

    typedef logic signed [SAMPLE_W-1:0] tri_table_t [TRI_PERIOD];

    // piecewise-linear triangle, one entry per phase
    function automatic tri_table_t tri_table_build();
        tri_table_t tbl;
        longint     v;
        for (int p = 0; p < TRI_PERIOD; p++) begin
            if (p < TRI_QUARTER) begin
                v = longint'(LEVEL_INT) * p / TRI_QUARTER;
            end else if (p < TRI_HALF) begin
                v = LEVEL_INT - longint'(LEVEL_INT) * (p - TRI_QUARTER) / TRI_QUARTER;
            end else if (p < TRI_THREEQ) begin
                v = -(longint'(LEVEL_INT) * (p - TRI_HALF) / TRI_QUARTER);
            end else begin
                v = -LEVEL_INT + longint'(LEVEL_INT) * (p - TRI_THREEQ) / TRI_QUARTER;
            end
            tbl[p] = SAMPLE_W'(v);
        end
        return tbl;
    endfunction

    localparam tri_table_t TRI_TABLE = tri_table_build();

endpackage

// File: rtl/core/mwtg_mul.sv
// shared signed 32x32 multiplier with registered product
// depends on mwtg_pkg
module mwtg_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [mwtg_pkg::OSC_W-1:0]    a,
    input  logic signed [mwtg_pkg::OSC_W-1:0]    b,
    output logic signed [mwtg_pkg::PROD_W-1:0]   prod
);
    import mwtg_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/mwtg_tri.sv
// triangle phase counter and table lookup
// depends on mwtg_pkg
module mwtg_tri (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,
    output logic signed [mwtg_pkg::SAMPLE_W-1:0]  value
);
    import mwtg_pkg::*;

    logic [TRI_PHASE_W-1:0] phase_reg;
    logic [TRI_PHASE_W-1:0] phase_next;

    always_comb begin
        if (phase_reg == TRI_PHASE_W'(TRI_PERIOD - 1)) begin
            phase_next = '0;
        end else begin
            phase_next = phase_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    assign value = TRI_TABLE[phase_reg];

endmodule

// File: rtl/core/multi_wave_tone_generator.sv
// multi-wave tone generator top level: sequencer, oscillator state, output register
// depends on mwtg_pkg, mwtg_mul, mwtg_tri and multi_wave_tone_generator_macros.svh
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata[0] sample_tick, rest zero
// m_axis    out  m_axis_tvalid/tready       tdata[15:0] sample
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// sine runs ST_ADVANCE, ST_SCALE_MUL and ST_SCALE_OUT from accept to result, square
// ST_ADVANCE only, triangle none; a tick of zero finishes in the accept cycle; the one
// shared multiplier is used once for the recurrence and once more for the sine scaling
// a new word is taken only when the sequencer is idle and the output is empty
// reset is synchronous, active low; config is accepted every cycle
module multi_wave_tone_generator (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [mwtg_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [0] sample_tick
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [mwtg_pkg::SAMPLE_W-1:0]          m_axis_tdata,  // [15:0] sample
    // register writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mwtg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mwtg_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import mwtg_pkg::*;
`include "multi_wave_tone_generator_macros.svh"

    // control
    state_t state_reg;
    state_t state_next;
    logic   in_accept;
    logic   cfg_write;

    // config registers
    wave_t                    wave_reg;
    logic signed [OSC_W-1:0]  coeff_reg;
    logic signed [OSC_W-1:0]  start_reg;

    // oscillator state
    logic signed [OSC_W-1:0]  osc_cur_reg;
    logic signed [OSC_W-1:0]  osc_prev_reg;

    // shared multiplier hookup
    logic                     mul_en;
    logic signed [OSC_W-1:0]  mul_a;
    logic signed [OSC_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    // triangle
    logic                       tri_step;
    logic signed [SAMPLE_W-1:0] tri_value;

    // datapath after the multiplier
    logic signed [PROD_W-Q_FRAC-1:0]   osc_floor;   // product >> 30, floor
    logic signed [PROD_W-Q_FRAC:0]     osc_diff;
    logic signed [OSC_W-1:0]           osc_new;
    logic signed [PROD_W-1:0]          scaled_adj;
    logic signed [PROD_W-Q_FRAC-1:0]   scaled_q;
    logic signed [SAMPLE_W-1:0]        sine_sample;

    // output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_load;
    logic signed [SAMPLE_W-1:0] out_load_value;

    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid && cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;

    mwtg_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    mwtg_tri u_tri (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (tri_step),
        .value   (tri_value)
    );

    // recurrence: floor(a*cur / 2^30) - prev, saturated to 32 bits
    always_comb begin
        osc_floor = mul_prod[PROD_W-1:Q_FRAC];
        osc_diff  = (PROD_W-Q_FRAC+1)'(osc_floor) - (PROD_W-Q_FRAC+1)'(osc_prev_reg);
        if (osc_diff[PROD_W-Q_FRAC:OSC_W-1] == '0 || osc_diff[PROD_W-Q_FRAC:OSC_W-1] == '1) begin
            osc_new = osc_diff[OSC_W-1:0];
        end else if (osc_diff[PROD_W-Q_FRAC]) begin
            osc_new = OSC_MIN;
        end else begin
            osc_new = OSC_MAX;
        end
    end

    // sine scaling: new*32000 / 2^30 toward zero, saturated to 16 bits
    always_comb begin
        scaled_adj = mul_prod + (mul_prod[PROD_W-1] ? TRUNC_BIAS : '0);
        scaled_q   = scaled_adj[PROD_W-1:Q_FRAC];
        if (scaled_q[PROD_W-Q_FRAC-1:SAMPLE_W-1] == '0 ||
            scaled_q[PROD_W-Q_FRAC-1:SAMPLE_W-1] == '1) begin
            sine_sample = scaled_q[SAMPLE_W-1:0];
        end else if (scaled_q[PROD_W-Q_FRAC-1]) begin
            sine_sample = SAMPLE_MIN;
        end else begin
            sine_sample = SAMPLE_MAX;
        end
    end

    // sequencer: next state and unit controls
    always_comb begin
        state_next     = state_reg;
        mul_en         = 1'b0;
        mul_a          = coeff_reg;
        mul_b          = osc_cur_reg;
        tri_step       = 1'b0;
        out_load       = 1'b0;
        out_load_value = tri_value;
        case (state_reg)
            ST_IDLE: begin
                // a zero tick is taken and dropped
                if (in_accept && s_axis_tdata[0]) begin
                    if (wave_reg == WAVE_TRIANGLE) begin
                        tri_step       = 1'b1;
                        out_load       = 1'b1;
                        out_load_value = tri_value;
                    end else begin
                        mul_en     = 1'b1;
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_ADVANCE: begin
                // oscillator registers take the new value on this edge unless a config write wins
                if (wave_reg == WAVE_SQUARE) begin
                    out_load       = 1'b1;
                    out_load_value = osc_new[OSC_W-1] ? '0 : LEVEL;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_SCALE_MUL;
                end
            end
            ST_SCALE_MUL: begin
                mul_en     = 1'b1;
                mul_a      = osc_cur_reg;
                mul_b      = SINE_SCALE;
                state_next = ST_SCALE_OUT;
            end
            ST_SCALE_OUT: begin
                out_load       = 1'b1;
                out_load_value = sine_sample;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // config registers; coeff or start write reloads the oscillator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg     <= WAVE_SINE;
            coeff_reg    <= COEFF_A_RESET;
            start_reg    <= START_VALUE_RESET;
            osc_cur_reg  <= START_VALUE_RESET;
            osc_prev_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_WAVE_TYPE: begin
                    wave_reg <= wave_t'(cfg_data[1:0]);
                end
                REG_COEFF_A: begin
                    coeff_reg    <= cfg_data;
                    osc_cur_reg  <= start_reg;
                    osc_prev_reg <= '0;
                end
                REG_START_VALUE: begin
                    start_reg    <= cfg_data;
                    osc_cur_reg  <= cfg_data;
                    osc_prev_reg <= '0;
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end else if (state_reg == ST_ADVANCE) begin
            osc_prev_reg <= osc_cur_reg;
            osc_cur_reg  <= osc_new;
        end
    end

    // output register holds one word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_sample_reg <= out_load_value;
        end
    end

    // triangle tick produces a word on the next cycle
    `MWTG_ASSERT_NXT(a_tri_result, aclk, aresetn,
        in_accept && s_axis_tdata[0] && wave_reg == WAVE_TRIANGLE, m_axis_tvalid)

    // oscillator tick starts the recurrence step
    `MWTG_ASSERT_NXT(a_osc_start, aclk, aresetn,
        in_accept && s_axis_tdata[0] && wave_reg != WAVE_TRIANGLE, state_reg == ST_ADVANCE)

    // the sine path always finishes with a word
    `MWTG_ASSERT_NXT(a_sine_done, aclk, aresetn,
        state_reg == ST_SCALE_OUT, m_axis_tvalid && state_reg == ST_IDLE)

    // no word is offered while the sequencer runs the multiplier
    `MWTG_ASSERT_IMP(a_busy_no_out, aclk, aresetn,
        state_reg == ST_ADVANCE || state_reg == ST_SCALE_MUL, !m_axis_tvalid)

endmodule

// File: dv/tb_multi_wave_tone_generator.sv
`timescale 1ns / 100ps
// self-checking testbench for the multi-wave tone generator: sample tracker class and top module
// depends on mwtg_pkg and the multi_wave_tone_generator rtl

// tracks the generator state and the samples still owed by the block
class tone_sample_tracker;
    mwtg_pkg::wave_t    wave;
    logic signed [31:0] coeff_a;
    logic signed [31:0] start_value;
    logic signed [31:0] osc_cur;
    logic signed [31:0] osc_prev;
    int unsigned        tri_phase;
    logic signed [15:0] pending_samples [$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        writes;
    int unsigned        requests;
    int unsigned        idle_ticks;
    int unsigned        per_wave [4];

    function new();
        wave        = mwtg_pkg::WAVE_SINE;
        coeff_a     = mwtg_pkg::COEFF_A_RESET;
        start_value = mwtg_pkg::START_VALUE_RESET;
        tri_phase   = 0;
        errors      = 0;
        checked     = 0;
        writes      = 0;
        requests    = 0;
        idle_ticks  = 0;
        foreach (per_wave[i]) per_wave[i] = 0;
        reload_osc();
    endfunction

    function void reload_osc();
        osc_cur  = start_value;
        osc_prev = 0;
    endfunction

    function void note_write(logic [1:0] index, logic [31:0] data);
        writes++;
        case (index)
            mwtg_pkg::REG_WAVE_TYPE: wave = mwtg_pkg::wave_t'(data[1:0]);
            mwtg_pkg::REG_COEFF_A: begin
                coeff_a = data;
                reload_osc();
            end
            mwtg_pkg::REG_START_VALUE: begin
                start_value = data;
                reload_osc();
            end
            default: ;
        endcase
    endfunction

    // one step of new = a*cur - prev, floor shift, saturated to 32 bits
    function longint advance_osc();
        longint prod;
        longint nv;
        prod = longint'(coeff_a) * longint'(osc_cur);
        nv   = (prod >>> mwtg_pkg::Q_FRAC) - longint'(osc_prev);
        if (nv > longint'(mwtg_pkg::OSC_MAX)) nv = longint'(mwtg_pkg::OSC_MAX);
        if (nv < longint'(mwtg_pkg::OSC_MIN)) nv = longint'(mwtg_pkg::OSC_MIN);
        osc_prev = osc_cur;
        osc_cur  = nv[31:0];
        return nv;
    endfunction

    // four linear segments, each slope truncated toward zero
    function logic signed [15:0] triangle_level();
        longint q;
        longint ph;
        longint v;
        q  = mwtg_pkg::TRI_QUARTER;
        ph = tri_phase;
        if (ph < mwtg_pkg::TRI_QUARTER)
            v = mwtg_pkg::LEVEL_INT * ph / q;
        else if (ph < mwtg_pkg::TRI_HALF)
            v = mwtg_pkg::LEVEL_INT - mwtg_pkg::LEVEL_INT * (ph - mwtg_pkg::TRI_QUARTER) / q;
        else if (ph < mwtg_pkg::TRI_THREEQ)
            v = -(mwtg_pkg::LEVEL_INT * (ph - mwtg_pkg::TRI_HALF) / q);
        else
            v = -mwtg_pkg::LEVEL_INT
                + mwtg_pkg::LEVEL_INT * (ph - mwtg_pkg::TRI_THREEQ) / q;
        return v[15:0];
    endfunction

    function void note_request(bit tick);
        longint s;
        if (!tick) begin
            idle_ticks++;
            return;
        end
        requests++;
        per_wave[wave]++;
        case (wave)
            mwtg_pkg::WAVE_SQUARE: s = (advance_osc() >= 0) ? mwtg_pkg::LEVEL_INT : 0;
            mwtg_pkg::WAVE_TRIANGLE: begin
                s = triangle_level();
                tri_phase = (tri_phase + 1) % mwtg_pkg::TRI_PERIOD;
            end
            default: begin
                s = advance_osc() * longint'(mwtg_pkg::SINE_SCALE)
                    / (64'sd1 <<< mwtg_pkg::Q_FRAC);
                if (s > longint'(mwtg_pkg::SAMPLE_MAX)) s = longint'(mwtg_pkg::SAMPLE_MAX);
                if (s < longint'(mwtg_pkg::SAMPLE_MIN)) s = longint'(mwtg_pkg::SAMPLE_MIN);
            end
        endcase
        pending_samples.push_back(s[15:0]);
    endfunction

    function void check_sample(logic [15:0] got);
        logic signed [15:0] want;
        if (pending_samples.size() == 0) begin
            errors++;
            $display("%0t: unexpected sample, expected none, actual %0d", $time, $signed(got));
            return;
        end
        want = pending_samples.pop_front();
        checked++;
        if (got !== want) begin
            errors++;
            $display("%0t: sample mismatch, expected %0d, actual %0d",
                     $time, want, $signed(got));
        end
    endfunction
endclass

module tb_multi_wave_tone_generator;
    import mwtg_pkg::*;

    // input words to send, idle ticks included
    localparam int          REQUEST_TARGET = 1900;
    localparam int unsigned MAX_GAP        = 17;
    // sine is the slowest path, leave some margin before a register write
    localparam int          SETTLE_CYCLES  = 8;
    // longest correct quiet stretch is a send gap plus a receive stall plus the pipeline
    localparam int          STALL_LIMIT    = 2000;
    // index past the register map, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic signed [31:0]   START_HI     = 32'sh4000_0000;
    localparam logic signed [31:0]   START_LO     = -START_HI;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;  // [0] sample_tick, rest zero
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]     m_axis_tdata;        // [15:0] sample
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;

    tone_sample_tracker tracker;
    int unsigned        send_gap_max  = 0;
    int unsigned        recv_stall_max = MAX_GAP;
    int unsigned        quiet_cycles  = 0;

    multi_wave_tone_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // reset held low from the start, released once
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // watchdog: any handshake clears the count of quiet cycles
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: take a word, then stall for a random number of cycles
    // ready is only lowered when a stall follows, so it never toggles within a step
    initial begin : sample_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            tracker.check_sample(m_axis_tdata);
            stall = $urandom_range(0, recv_stall_max);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // one request word; valid stays high into the next word when no gap is drawn
    task automatic send_request(bit tick);
        int unsigned gap;
        s_axis_tdata  <= IN_TDATA_W'(tick);
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        tracker.note_request(tick);
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // register write; valid is dropped by close_writes once a group is done
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        tracker.note_write(index, data);
    endtask

    task automatic close_writes();
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every owed sample is back, then let the core go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random register settings between phases, extremes weighted in
    task automatic program_random();
        logic [31:0] value;
        if ($urandom_range(0, 1) == 0) write_reg(REG_WAVE_TYPE, $urandom);
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
                0:       value = OSC_MAX;
                1:       value = OSC_MIN;
                2:       value = COEFF_A_RESET;
                default: value = $urandom;
            endcase
            write_reg(REG_COEFF_A, value);
        end
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
                0:       value = START_HI;
                1:       value = START_LO;
                2:       value = '0;
                default: value = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
            endcase
            write_reg(REG_START_VALUE, value);
        end
        if ($urandom_range(0, 15) == 0) write_reg(REG_UNMAPPED, $urandom);
        close_writes();
    endtask

    initial begin : stimulus
        int unsigned n;
        tracker = new();
        wait (aresetn === 1'b1);
        @(posedge aclk);

        // directed: reset settings, an idle tick first
        send_gap_max = 0;
        send_request(1'b0);
        repeat (3) send_request(1'b1);
        settle();

        // square, then triangle, then the default sine code
        write_reg(REG_WAVE_TYPE, CFG_DATA_W'(WAVE_SQUARE));
        close_writes();
        repeat (2) send_request(1'b1);
        settle();
        write_reg(REG_WAVE_TYPE, CFG_DATA_W'(WAVE_TRIANGLE));
        close_writes();
        repeat (3) send_request(1'b1);
        settle();
        write_reg(REG_WAVE_TYPE, CFG_DATA_W'(WAVE_SINE_DEF));
        close_writes();
        repeat (2) send_request(1'b1);
        settle();

        // write past the register map must change nothing
        write_reg(REG_UNMAPPED, $urandom);
        close_writes();
        send_request(1'b1);
        settle();

        // largest coefficient and start: oscillator and sample both saturate high
        write_reg(REG_WAVE_TYPE, CFG_DATA_W'(WAVE_SINE));
        write_reg(REG_COEFF_A, OSC_MAX);
        write_reg(REG_START_VALUE, START_HI);
        close_writes();
        repeat (4) send_request(1'b1);
        settle();

        // most negative coefficient and start: sign flips each step, both rails hit
        write_reg(REG_COEFF_A, OSC_MIN);
        write_reg(REG_START_VALUE, START_LO);
        close_writes();
        repeat (4) send_request(1'b1);
        settle();
        write_reg(REG_WAVE_TYPE, CFG_DATA_W'(WAVE_SQUARE));
        close_writes();
        repeat (2) send_request(1'b1);

        // random phases: new settings, then a burst of mostly real ticks
        while (tracker.requests + tracker.idle_ticks < REQUEST_TARGET) begin
            settle();
            send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            program_random();
            n = $urandom_range(20, 200);
            repeat (n) begin
                // now and then hold off until the block has handed back everything
                if ($urandom_range(0, 63) == 0) settle();
                send_request($urandom_range(0, 9) != 0);
            end
        end

        settle();
        $display("%0d sample requests: sine %0d, square %0d, triangle %0d, default %0d",
                 tracker.requests, tracker.per_wave[WAVE_SINE], tracker.per_wave[WAVE_SQUARE],
                 tracker.per_wave[WAVE_TRIANGLE], tracker.per_wave[WAVE_SINE_DEF]);
        $display("%0d idle ticks, %0d samples checked, %0d register writes, %0d errors",
                 tracker.idle_ticks, tracker.checked, tracker.writes, tracker.errors);
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
